// File: sv/rc_channel_frame_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the servo-bus frame decoder
// Shared property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_FRAME_DECODER_TOP_ASSERT_SVH
`define RC_CHANNEL_FRAME_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Types, codes and constants of the servo-bus frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfd_pkg;

   localparam int CHANNELS_DEFAULT = 14;
   localparam int SLOTS            = 14;

   localparam int OPCODE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int CHAN_W   = 4;
   localparam int VALUE_W  = 16;
   localparam int COUNT_W  = 32;
   localparam int POS_W    = 5;
   localparam int CSR_IDX_W = 1;

   // Input opcodes.
   localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHANNEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_THRESHOLD = 1'd1;

   localparam logic [VALUE_W-1:0] WINDOW_TICKS_RESET   = 16'd400;
   localparam logic [VALUE_W-1:0] MOVE_THRESHOLD_RESET = 16'd60;

   localparam logic [BYTE_W-1:0]  HEADER0   = 8'h20;
   localparam logic [BYTE_W-1:0]  HEADER1   = 8'h40;
   localparam logic [VALUE_W-1:0] ALL_ONES  = 16'hFFFF;
   localparam logic [POS_W-1:0]   POS_CSUM_LO = 5'd30;
   localparam logic [POS_W-1:0]   POS_FIRST_DATA = 5'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FRAME,
      ST_SCAN,
      ST_SDONE,
      ST_PUT
   } state_type;

endpackage

`default_nettype wire

// File: sv/rc_channel_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder_top
// Servo-bus frame decoder with per-channel movement window.
//
// Input beats (req_) carry an opcode: a received byte, a millisecond tick or
// a clear of counters and window. Result beats (rsp_) carry a status, one
// channel value each of a good frame, or a movement report; rsp_last marks
// the final beat of an input. The csr_ port writes window_ticks (index 0)
// and move_threshold (index 1); it is always ready.
// One small sequencer handles an input at a time and req_stall is high while
// it works. A byte or clear gives its single beat from the PUT state.
// A good frame then streams CHANNELS beats, one per cycle unless rsp_stall
// holds it, each beat also updating that channel's window min and max. A tick
// that ends the window scans the channels through one subtract and compare unit,
// one channel per cycle, then reports through the SDONE and PUT states.
// The next input can be taken while the last beat still waits in the output
// register. A stalled receiver holds the output register and the sequencer.
// Reset clears the frame hunt, both counters and the window, and restores
// the register defaults 400 and 60.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc_channel_frame_decoder_top_assert.svh"

module rc_channel_frame_decoder_top #(
   parameter int CHANNELS = rcfd_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [rcfd_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]    req_rx_byte,

   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [rcfd_pkg::KIND_W-1:0]    rsp_kind,
   output      logic [rcfd_pkg::CHAN_W-1:0]    rsp_channel,
   output      logic [rcfd_pkg::VALUE_W-1:0]   rsp_value,
   output      logic [rcfd_pkg::VALUE_W-1:0]   rsp_span_top,
   output      logic                           rsp_frame_done,
   output      logic                           rsp_frame_ok,
   output      logic [rcfd_pkg::COUNT_W-1:0]   rsp_good_frames,
   output      logic [rcfd_pkg::COUNT_W-1:0]   rsp_bad_frames,
   output      logic                           rsp_last,

   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [rcfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rcfd_pkg::VALUE_W-1:0]   csr_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   typedef logic [rcfd_pkg::VALUE_W-1:0] word_type;

   // Control and configuration state.
   rcfd_pkg::state_type              state_ff, state_in;
   logic [rcfd_pkg::VALUE_W-1:0]     win_ticks_ff, win_ticks_in;
   logic [rcfd_pkg::VALUE_W-1:0]     threshold_ff, threshold_in;
   logic [rcfd_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [rcfd_pkg::VALUE_W-1:0]     sum_ff, sum_in;
   logic [rcfd_pkg::BYTE_W-1:0]      low_ff, low_in;
   logic [rcfd_pkg::COUNT_W-1:0]     good_ff, good_in;
   logic [rcfd_pkg::COUNT_W-1:0]     bad_ff, bad_in;
   logic [rcfd_pkg::VALUE_W-1:0]     elapsed_ff, elapsed_in;
   word_type                         min_ff [CHANNELS];
   word_type                         min_in [CHANNELS];
   word_type                         max_ff [CHANNELS];
   word_type                         max_in [CHANNELS];
   logic                             rsp_valid_ff, rsp_valid_in;

   // Working registers (no reset needed).
   word_type                         pend_ff [CHANNELS];
   word_type                         pend_in [CHANNELS];
   logic [rcfd_pkg::OPCODE_W-1:0]    op_ff, op_in;
   logic [rcfd_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic [IDX_W-1:0]                 chan_ff, chan_in;
   logic [rcfd_pkg::VALUE_W-1:0]     widest_ff, widest_in;
   logic [IDX_W-1:0]                 best_ff, best_in;
   logic                             found_ff, found_in;
   logic [rcfd_pkg::KIND_W-1:0]      stage_kind_ff, stage_kind_in;
   logic [rcfd_pkg::CHAN_W-1:0]      stage_chan_ff, stage_chan_in;
   logic [rcfd_pkg::VALUE_W-1:0]     stage_value_ff, stage_value_in;
   logic [rcfd_pkg::VALUE_W-1:0]     stage_top_ff, stage_top_in;
   logic                             stage_done_ff, stage_done_in;
   logic [rcfd_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [rcfd_pkg::CHAN_W-1:0]      channel_ff, channel_in;
   logic [rcfd_pkg::VALUE_W-1:0]     value_ff, value_in;
   logic [rcfd_pkg::VALUE_W-1:0]     top_ff, top_in;
   logic                             done_ff, done_in;
   logic                             ok_ff, ok_in;
   logic [rcfd_pkg::COUNT_W-1:0]     good_rsp_ff, good_rsp_in;
   logic [rcfd_pkg::COUNT_W-1:0]     bad_rsp_ff, bad_rsp_in;
   logic                             last_ff, last_in;

   logic                             out_free;
   logic [rcfd_pkg::VALUE_W-1:0]     sum_add;
   logic [rcfd_pkg::POS_W-1:0]       slot_full;
   logic [rcfd_pkg::CHAN_W-1:0]      slot;
   logic [rcfd_pkg::VALUE_W-1:0]     got_csum;
   logic [rcfd_pkg::VALUE_W-1:0]     elapsed_next;
   logic [rcfd_pkg::VALUE_W-1:0]     span;
   logic                             chan_last;

   assign req_stall = (state_ff != rcfd_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign chan_last = (chan_ff == LAST_IDX);

   assign sum_add      = sum_ff + {8'd0, byte_ff};
   assign slot_full    = (pos_ff - rcfd_pkg::POS_FIRST_DATA) >> 1;
   assign slot         = slot_full[rcfd_pkg::CHAN_W-1:0];
   assign got_csum     = {byte_ff, low_ff};
   assign elapsed_next = (elapsed_ff == rcfd_pkg::ALL_ONES) ? elapsed_ff
                                                             : elapsed_ff + 16'd1;
   // The one shared subtractor of the window scan.
   assign span         = max_ff[chan_ff] - min_ff[chan_ff];

   always_comb begin
      state_in      = state_ff;
      win_ticks_in  = win_ticks_ff;
      threshold_in  = threshold_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      low_in        = low_ff;
      good_in       = good_ff;
      bad_in        = bad_ff;
      elapsed_in    = elapsed_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      pend_in       = pend_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      chan_in       = chan_ff;
      widest_in     = widest_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      stage_kind_in  = stage_kind_ff;
      stage_chan_in  = stage_chan_ff;
      stage_value_in = stage_value_ff;
      stage_top_in   = stage_top_ff;
      stage_done_in  = stage_done_ff;
      kind_in       = kind_ff;
      channel_in    = channel_ff;
      value_in      = value_ff;
      top_in        = top_ff;
      done_in       = done_ff;
      ok_in         = ok_ff;
      good_rsp_in   = good_rsp_ff;
      bad_rsp_in    = bad_rsp_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         case (csr_index)
            rcfd_pkg::REG_WINDOW_TICKS:   win_ticks_in = csr_data;
            rcfd_pkg::REG_MOVE_THRESHOLD: threshold_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         rcfd_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               byte_in  = req_rx_byte;
               state_in = rcfd_pkg::ST_EXEC;
            end
         end

         rcfd_pkg::ST_EXEC: begin
            stage_kind_in  = rcfd_pkg::KIND_STATUS;
            stage_chan_in  = '0;
            stage_value_in = '0;
            stage_top_in   = '0;
            stage_done_in  = 1'b0;
            state_in       = rcfd_pkg::ST_PUT;
            case (op_ff)
               rcfd_pkg::OP_BYTE: begin
                  if (pos_ff == '0) begin
                     if (byte_ff == rcfd_pkg::HEADER0) begin
                        sum_in = {8'd0, rcfd_pkg::HEADER0};
                        pos_in = 5'd1;
                     end
                  end else if (pos_ff == 5'd1) begin
                     if (byte_ff == rcfd_pkg::HEADER1) begin
                        sum_in = sum_add;
                        pos_in = rcfd_pkg::POS_FIRST_DATA;
                     end else if (byte_ff == rcfd_pkg::HEADER0) begin
                        // A repeated first header byte starts a new frame.
                        sum_in = {8'd0, rcfd_pkg::HEADER0};
                        pos_in = 5'd1;
                     end else begin
                        pos_in = '0;
                     end
                  end else if (pos_ff < rcfd_pkg::POS_CSUM_LO) begin
                     sum_in = sum_add;
                     if (!pos_ff[0]) begin
                        low_in = byte_ff;
                     end else if (32'(slot) < CHANNELS) begin
                        pend_in[slot[IDX_W-1:0]] = {byte_ff, low_ff};
                     end
                     pos_in = pos_ff + 5'd1;
                  end else if (pos_ff == rcfd_pkg::POS_CSUM_LO) begin
                     low_in = byte_ff;
                     pos_in = pos_ff + 5'd1;
                  end else begin
                     pos_in = '0;
                     if (got_csum != (rcfd_pkg::ALL_ONES - sum_ff)) begin
                        bad_in        = bad_ff + 32'd1;
                        stage_done_in = 1'b1;
                     end else begin
                        good_in  = good_ff + 32'd1;
                        chan_in  = '0;
                        state_in = rcfd_pkg::ST_FRAME;
                     end
                  end
               end
               rcfd_pkg::OP_TICK: begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= win_ticks_ff) begin
                     chan_in   = '0;
                     widest_in = '0;
                     best_in   = '0;
                     found_in  = 1'b0;
                     state_in  = rcfd_pkg::ST_SCAN;
                  end
               end
               rcfd_pkg::OP_CLEAR: begin
                  good_in    = '0;
                  bad_in     = '0;
                  elapsed_in = '0;
                  for (int i = 0; i < CHANNELS; i++) begin
                     min_in[i] = rcfd_pkg::ALL_ONES;
                     max_in[i] = '0;
                  end
               end
               default: ;
            endcase
         end

         rcfd_pkg::ST_FRAME: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = rcfd_pkg::KIND_CHANNEL;
               channel_in   = rcfd_pkg::CHAN_W'(chan_ff);
               value_in     = pend_ff[chan_ff];
               top_in       = '0;
               done_in      = 1'b1;
               ok_in        = 1'b1;
               good_rsp_in  = good_ff;
               bad_rsp_in   = bad_ff;
               last_in      = chan_last;
               if (pend_ff[chan_ff] < min_ff[chan_ff]) begin
                  min_in[chan_ff] = pend_ff[chan_ff];
               end
               if (pend_ff[chan_ff] > max_ff[chan_ff]) begin
                  max_in[chan_ff] = pend_ff[chan_ff];
               end
               if (chan_last) begin
                  state_in = rcfd_pkg::ST_IDLE;
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
            end
         end

         rcfd_pkg::ST_SCAN: begin
            // A channel without a sample has max below min and is skipped.
            if (max_ff[chan_ff] >= min_ff[chan_ff] && span > widest_ff) begin
               widest_in = span;
               best_in   = chan_ff;
               found_in  = 1'b1;
            end
            if (chan_last) begin
               state_in = rcfd_pkg::ST_SDONE;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end

         rcfd_pkg::ST_SDONE: begin
            if (found_ff && widest_ff >= threshold_ff) begin
               stage_kind_in  = rcfd_pkg::KIND_MOVE;
               stage_chan_in  = rcfd_pkg::CHAN_W'(best_ff);
               stage_value_in = min_ff[best_ff];
               stage_top_in   = max_ff[best_ff];
            end
            elapsed_in = '0;
            for (int i = 0; i < CHANNELS; i++) begin
               min_in[i] = rcfd_pkg::ALL_ONES;
               max_in[i] = '0;
            end
            state_in = rcfd_pkg::ST_PUT;
         end

         rcfd_pkg::ST_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = stage_kind_ff;
               channel_in   = stage_chan_ff;
               value_in     = stage_value_ff;
               top_in       = stage_top_ff;
               done_in      = stage_done_ff;
               ok_in        = 1'b0;
               good_rsp_in  = good_ff;
               bad_rsp_in   = bad_ff;
               last_in      = 1'b1;
               state_in     = rcfd_pkg::ST_IDLE;
            end
         end

         default: state_in = rcfd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcfd_pkg::ST_IDLE;
         win_ticks_ff <= rcfd_pkg::WINDOW_TICKS_RESET;
         threshold_ff <= rcfd_pkg::MOVE_THRESHOLD_RESET;
         pos_ff       <= '0;
         sum_ff       <= '0;
         low_ff       <= '0;
         good_ff      <= '0;
         bad_ff       <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            min_ff[i] <= rcfd_pkg::ALL_ONES;
            max_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         win_ticks_ff <= win_ticks_in;
         threshold_ff <= threshold_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         low_ff       <= low_in;
         good_ff      <= good_in;
         bad_ff       <= bad_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff        <= pend_in;
      op_ff          <= op_in;
      byte_ff        <= byte_in;
      chan_ff        <= chan_in;
      widest_ff      <= widest_in;
      best_ff        <= best_in;
      found_ff       <= found_in;
      stage_kind_ff  <= stage_kind_in;
      stage_chan_ff  <= stage_chan_in;
      stage_value_ff <= stage_value_in;
      stage_top_ff   <= stage_top_in;
      stage_done_ff  <= stage_done_in;
      kind_ff        <= kind_in;
      channel_ff     <= channel_in;
      value_ff       <= value_in;
      top_ff         <= top_in;
      done_ff        <= done_in;
      ok_ff          <= ok_in;
      good_rsp_ff    <= good_rsp_in;
      bad_rsp_ff     <= bad_rsp_in;
      last_ff        <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_channel     = channel_ff;
   assign rsp_value       = value_ff;
   assign rsp_span_top    = top_ff;
   assign rsp_frame_done  = done_ff;
   assign rsp_frame_ok    = ok_ff;
   assign rsp_good_frames = good_rsp_ff;
   assign rsp_bad_frames  = bad_rsp_ff;
   assign rsp_last        = last_ff;

   `RCFD_ASSERT_NEXT(a_accept_starts_exec, clock, reset, req_valid && !req_stall, state_ff == rcfd_pkg::ST_EXEC, "accepted beat did not start execution")
   `RCFD_ASSERT_SAME(a_channel_beat_ok, clock, reset, rsp_valid && rsp_kind == rcfd_pkg::KIND_CHANNEL, rsp_frame_done && rsp_frame_ok, "channel beat without good frame flags")
   `RCFD_ASSERT_SAME(a_move_span_positive, clock, reset, rsp_valid && rsp_kind == rcfd_pkg::KIND_MOVE, rsp_span_top > rsp_value, "movement report with empty span")
   `RCFD_ASSERT_NEXT(a_frame_counts_stable, clock, reset, state_ff == rcfd_pkg::ST_FRAME, $stable(good_ff) && $stable(bad_ff), "frame counters moved during channel output")

endmodule

`default_nettype wire
